FILE: sv/key_switch_arming_sequencer_top_macros.svh
// Assertion helpers for the key switch arming sequencer.
`ifndef KEY_SWITCH_ARMING_SEQUENCER_TOP_MACROS_SVH
`define KEY_SWITCH_ARMING_SEQUENCER_TOP_MACROS_SVH

`ifndef SYNTH
// Consequent must hold in the same cycle as the antecedent.
`define KSAS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("key switch sequencer check failed");
// Consequent must hold in the cycle after the antecedent.
`define KSAS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("key switch sequencer check failed");
`else
`define KSAS_ASSERT_SAME(label, clk, rst, ante, cons)
`define KSAS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: sv/ksas_pkg.sv
package ksas_pkg;

   typedef enum logic [3:0] {
      MODE_WAIT_OFF   = 4'd0,
      MODE_OFF_STOP   = 4'd1,
      MODE_OFF_DISARM = 4'd2,
      MODE_OFF_IDLE   = 4'd3,
      MODE_OFF_FAILED = 4'd4,
      MODE_ARMING     = 4'd5,
      MODE_ACTIVE     = 4'd6,
      MODE_MODE_LOST  = 4'd7,
      MODE_ARM_FAILED = 4'd8,
      MODE_AUTO       = 4'd9,
      MODE_FAULT      = 4'd10
   } mode_type;

   typedef enum logic [1:0] {
      KEY_OFF     = 2'd0,
      KEY_LOCAL   = 2'd1,
      KEY_AUTO    = 2'd2,
      KEY_INVALID = 2'd3
   } key_type;

   localparam logic KIND_TICK  = 1'b0;
   localparam logic KIND_START = 1'b1;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 32;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_STOP_SPEED      = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_STOP_WAIT       = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DISARM_TIMEOUT  = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ARM_TIMEOUT     = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MANUAL_CODE     = 3'd4;

   localparam logic [15:0] STOP_SPEED_RESET     = 16'd10;
   localparam logic [31:0] STOP_WAIT_RESET      = 32'd5000;
   localparam logic [31:0] DISARM_TIMEOUT_RESET = 32'd3000;
   localparam logic [31:0] ARM_TIMEOUT_RESET    = 32'd3000;
   localparam logic [7:0]  MANUAL_CODE_RESET    = 8'd0;

   typedef struct packed {
      logic               kind;
      logic [1:0]         key;
      logic [31:0]        now_ms;
      logic               have_speed;
      logic signed [15:0] speed_cms;
      logic               heartbeat_live;
      logic               is_armed;
      logic [7:0]         mode_code;
      logic               arm_ack_seen;
      logic               arm_ack_ok;
      logic               disarm_ack_seen;
      logic               disarm_ack_ok;
   } req_type;

   typedef struct packed {
      logic       hold_request;
      logic       arm_request;
      logic       manual_request;
      logic       disarm_request;
      logic       neutral_request;
      logic       invalid_key_warning;
      logic       mode_mismatch_warning;
      logic [3:0] mode_now;
   } rsp_type;

   typedef struct packed {
      logic [15:0] stop_speed_threshold_cms;
      logic [31:0] stop_wait_timeout_ms;
      logic [31:0] disarm_confirm_timeout_ms;
      logic [31:0] arm_confirm_timeout_ms;
      logic [7:0]  manual_mode_code;
   } cfg_type;

   typedef struct packed {
      mode_type    mode;
      key_type     previous_key;
      logic [31:0] entered_time;
   } seq_state_type;

   function automatic logic in_local_drive(mode_type m);
      return (m == MODE_ARMING) || (m == MODE_ACTIVE) ||
             (m == MODE_MODE_LOST) || (m == MODE_ARM_FAILED);
   endfunction

endpackage

FILE: sv/ksas_step.sv
module ksas_step (
   input  ksas_pkg::req_type       item,
   input  ksas_pkg::seq_state_type state_cur,
   input  ksas_pkg::cfg_type       cfg,
   output ksas_pkg::seq_state_type state_nxt,
   output ksas_pkg::rsp_type       result
);
   import ksas_pkg::*;

   key_type     key;
   logic [31:0] elapsed;
   logic        stopped;
   logic        local_drive;

   assign key         = key_type'(item.key);
   assign elapsed     = item.now_ms - state_cur.entered_time;
   assign stopped     = item.have_speed &&
                        (item.speed_cms < $signed({1'b0, cfg.stop_speed_threshold_cms}));
   assign local_drive = in_local_drive(state_cur.mode);

   always_comb begin
      state_nxt = state_cur;
      state_nxt.previous_key = key;
      result = '0;

      if (item.kind == KIND_START) begin
         state_nxt.entered_time = item.now_ms;
         case (key)
            KEY_OFF: begin
               state_nxt.mode = MODE_OFF_STOP;
               result.hold_request = 1'b1;
            end
            KEY_INVALID: begin
               state_nxt.mode = MODE_FAULT;
               result.invalid_key_warning = 1'b1;
            end
            default: state_nxt.mode = MODE_WAIT_OFF;
         endcase
      end else if (key == KEY_INVALID) begin
         // stamp the time only on entry into fault
         if (state_cur.mode != MODE_FAULT) begin
            result.neutral_request = local_drive;
            state_nxt.mode = MODE_FAULT;
            state_nxt.entered_time = item.now_ms;
         end
         result.invalid_key_warning = 1'b1;
      end else if (key != state_cur.previous_key) begin
         result.neutral_request = local_drive && (key != KEY_LOCAL);
         state_nxt.entered_time = item.now_ms;
         case (key)
            KEY_OFF: begin
               state_nxt.mode = MODE_OFF_STOP;
               result.hold_request = 1'b1;
            end
            KEY_LOCAL: begin
               state_nxt.mode = MODE_ARMING;
               result.arm_request = 1'b1;
               result.manual_request = 1'b1;
            end
            default: state_nxt.mode = MODE_AUTO;
         endcase
      end else begin
         case (state_cur.mode)
            MODE_OFF_STOP: begin
               if (stopped) begin
                  state_nxt.mode = MODE_OFF_DISARM;
                  state_nxt.entered_time = item.now_ms;
                  result.disarm_request = 1'b1;
               end else if (elapsed > cfg.stop_wait_timeout_ms) begin
                  state_nxt.mode = MODE_OFF_FAILED;
                  state_nxt.entered_time = item.now_ms;
               end
            end
            MODE_OFF_DISARM: begin
               if (item.disarm_ack_seen && !item.disarm_ack_ok) begin
                  state_nxt.mode = MODE_OFF_FAILED;
                  state_nxt.entered_time = item.now_ms;
               end else if (item.heartbeat_live && !item.is_armed) begin
                  state_nxt.mode = MODE_OFF_IDLE;
                  state_nxt.entered_time = item.now_ms;
               end else if (elapsed > cfg.disarm_confirm_timeout_ms) begin
                  state_nxt.mode = MODE_OFF_FAILED;
                  state_nxt.entered_time = item.now_ms;
               end
            end
            MODE_ARMING: begin
               if (item.arm_ack_seen && !item.arm_ack_ok) begin
                  state_nxt.mode = MODE_ARM_FAILED;
                  state_nxt.entered_time = item.now_ms;
               end else if (item.heartbeat_live && item.is_armed) begin
                  state_nxt.mode = MODE_ACTIVE;
                  state_nxt.entered_time = item.now_ms;
               end else if (elapsed > cfg.arm_confirm_timeout_ms) begin
                  state_nxt.mode = MODE_ARM_FAILED;
                  state_nxt.entered_time = item.now_ms;
               end
            end
            MODE_ACTIVE: begin
               if (!item.heartbeat_live || !item.is_armed ||
                   (item.mode_code != cfg.manual_mode_code)) begin
                  result.neutral_request = 1'b1;
                  result.hold_request = 1'b1;
                  result.mode_mismatch_warning = 1'b1;
                  state_nxt.mode = MODE_MODE_LOST;
                  state_nxt.entered_time = item.now_ms;
               end
            end
            MODE_MODE_LOST: result.mode_mismatch_warning = 1'b1;
            MODE_FAULT:     result.invalid_key_warning = 1'b1;
            default: ;
         endcase
      end

      result.mode_now = state_nxt.mode;
   end

endmodule

FILE: sv/key_switch_arming_sequencer_top.sv
// A transaction waits in the input register until the result register can take it. Throughput:
// one transaction per cycle while rsp_stall is low; the input and result registers form a
// two-stage pipeline and the sequencer state updates as each item enters the result register.
// Reset: clears both stages, loads the register defaults and returns the
// sequencer to wait-off with the key taken as off and the entry time at zero.
`include "key_switch_arming_sequencer_top_macros.svh"

module key_switch_arming_sequencer_top (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  ksas_pkg::req_type                         req_data,
   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output ksas_pkg::rsp_type                         rsp_data,
   input  logic                                      csr_write,
   input  logic [ksas_pkg::CSR_INDEX_WIDTH-1:0]      csr_index,
   input  logic [ksas_pkg::CSR_DATA_WIDTH-1:0]       csr_data
);
   import ksas_pkg::*;

   logic          in_valid_ff;
   logic          in_valid_in;
   req_type       in_data_ff;
   logic          out_valid_ff;
   logic          out_valid_in;
   rsp_type       out_data_ff;
   seq_state_type state_ff;
   seq_state_type state_in;
   cfg_type       cfg_ff;
   rsp_type       step_result;
   logic          out_advance;
   logic          step_fire;

   // result register can take a new item when empty or being drained
   assign out_advance = !out_valid_ff || !rsp_stall;
   assign step_fire   = in_valid_ff && out_advance;
   assign req_stall   = in_valid_ff && !out_advance;

   assign in_valid_in  = req_valid || (in_valid_ff && !out_advance);
   assign out_valid_in = step_fire || (out_valid_ff && rsp_stall);

   ksas_step u_step (
      .item      (in_data_ff),
      .state_cur (state_ff),
      .cfg       (cfg_ff),
      .state_nxt (state_in),
      .result    (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data;
      end
      if (step_fire) begin
         out_data_ff <= step_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.mode         <= MODE_WAIT_OFF;
         state_ff.previous_key <= KEY_OFF;
         state_ff.entered_time <= '0;
      end else if (step_fire) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stop_speed_threshold_cms  <= STOP_SPEED_RESET;
         cfg_ff.stop_wait_timeout_ms      <= STOP_WAIT_RESET;
         cfg_ff.disarm_confirm_timeout_ms <= DISARM_TIMEOUT_RESET;
         cfg_ff.arm_confirm_timeout_ms    <= ARM_TIMEOUT_RESET;
         cfg_ff.manual_mode_code          <= MANUAL_CODE_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_STOP_SPEED:     cfg_ff.stop_speed_threshold_cms  <= csr_data[15:0];
            CSR_STOP_WAIT:      cfg_ff.stop_wait_timeout_ms      <= csr_data[31:0];
            CSR_DISARM_TIMEOUT: cfg_ff.disarm_confirm_timeout_ms <= csr_data[31:0];
            CSR_ARM_TIMEOUT:    cfg_ff.arm_confirm_timeout_ms    <= csr_data[31:0];
            CSR_MANUAL_CODE:    cfg_ff.manual_mode_code          <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   `KSAS_ASSERT_NEXT(a_state_tracks_result, clock, reset, step_fire, rsp_valid && (rsp_data.mode_now == state_ff.mode))
   `KSAS_ASSERT_SAME(a_key_warning_in_fault, clock, reset, rsp_valid && rsp_data.invalid_key_warning, rsp_data.mode_now == MODE_FAULT)
   `KSAS_ASSERT_SAME(a_arm_with_manual, clock, reset, rsp_valid, rsp_data.arm_request == rsp_data.manual_request)
   `KSAS_ASSERT_SAME(a_stall_only_when_full, clock, reset, req_stall, in_valid_ff && rsp_valid && rsp_stall)

endmodule
